// ===== sv/dbc8_pkg.sv =====
// ----------------------------------------------------------------------------
// dbc8_pkg: shared types, constants and helpers
// Widths, decimal constants and the lane record passed between round cells.
// ----------------------------------------------------------------------------
package dbc8_pkg;

    localparam int VAL_W     = 27;
    localparam int KEY_W     = 32;
    localparam int ROUNDS    = 8;
    localparam int NUM_KEYS  = 8;
    localparam int KIDX_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int TOP_W     = 24;

    // key reduction: 10^8 = 2^8 * 390625, quotient estimate by reciprocal
    localparam int KEY_PRE_SH  = 8;
    localparam int KEY_RECIP_W = 12;
    localparam int KEY_SHIFT   = 30;
    localparam int KEY_Q_W     = 6;

    localparam logic [VAL_W-1:0]       DEC_MOD   = 27'd100000000;
    localparam logic [VAL_W+1:0]       DEC_MOD2  = 29'd200000000;
    localparam logic [TOP_W-1:0]       DEC_TOP   = 24'd10000000;
    localparam logic [KEY_W-1:0]       INV3      = 32'hAAAAAAAB;
    localparam logic [KEY_W-1:0]       RECIP10   = 32'hCCCCCCCD;
    // floor(2^30 / 390625); estimate is never above the quotient, at most one below
    localparam logic [KEY_RECIP_W-1:0] KEY_RECIP = 12'd2748;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef struct packed {
        logic             v;
        logic             kind;
        logic [VAL_W-1:0] a;
    } t_lane;

    // residue mod 3 from base-4 digit sum (4 == 1 mod 3)
    function automatic logic [1:0] mod3_val(input logic [VAL_W-1:0] x);
        logic [VAL_W:0] xe;
        logic [5:0]     s;
        logic [3:0]     s2;
        xe = {1'b0, x};
        s  = '0;
        for (int i = 0; i < (VAL_W + 1) / 2; i++) begin
            s = s + 6'(xe[2*i +: 2]);
        end
        s2 = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        if (s2 >= 4'd6) begin
            s2 = s2 - 4'd6;
        end else if (s2 >= 4'd3) begin
            s2 = s2 - 4'd3;
        end
        return s2[1:0];
    endfunction

    // digit times 10^7
    function automatic logic [VAL_W-1:0] top_scale(input logic [3:0] d);
        return VAL_W'(d) * VAL_W'(DEC_TOP);
    endfunction

endpackage

// ===== sv/decimal_block_cipher_8digit_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_block_cipher_8digit_unit: eight-digit decimal block cipher
// Input register, a chain of round cells, then an output register with skid.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while o_stall is low; each round cell is
// a four-stage pipeline. A key write keeps o_cfg_ready and input acceptance
// off while the word is reduced mod 10^8: quotient estimate, then a
// correcting subtract.
// Reset (synchronous, active low) clears all keys to zero and empties the pipe.
module decimal_block_cipher_8digit_unit import dbc8_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic [VAL_W-1:0]     i_value_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [VAL_W-1:0]     o_value_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data
);

    logic                           w_busy;
    logic [NUM_KEYS-1:0][VAL_W-1:0] w_keys;
    logic                           w_en;
    logic                           w_accept;
    logic                           w_take;
    t_lane                          w_lane [ROUNDS+1];

    t_lane            r_in;
    logic             r_out_v;
    logic [VAL_W-1:0] r_out_val;
    logic             r_skid_v;
    logic [VAL_W-1:0] r_skid_val;

    dbc8_key_store u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (w_busy),
        .o_keys      (w_keys)
    );

    // the chain moves whenever the skid slot is free
    assign w_en     = !r_skid_v;
    assign o_stall  = !w_en || w_busy;
    assign w_accept = i_valid && !o_stall;
    assign w_take   = r_out_v && !i_stall;

    // values at or above 10^8 behave as their residue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.v <= 1'b0;
        end else if (w_en) begin
            r_in.v <= w_accept;
        end
        if (w_en) begin
            r_in.kind <= i_kind;
            r_in.a    <= (i_value_in >= DEC_MOD) ? i_value_in - DEC_MOD : i_value_in;
        end
    end

    assign w_lane[0] = r_in;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        dbc8_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_lane    (w_lane[g]),
            .i_key_enc (w_keys[g]),
            .i_key_dec (w_keys[ROUNDS-1-g]),
            .o_lane    (w_lane[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_lane[ROUNDS].v) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out_val <= r_skid_val;
            end
        end else if (w_lane[ROUNDS].v) begin
            if (!r_out_v || w_take) begin
                r_out_val <= w_lane[ROUNDS].a;
            end else begin
                r_skid_val <= w_lane[ROUNDS].a;
            end
        end
    end

    assign o_valid     = r_out_v;
    assign o_value_out = r_out_val;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid item held with empty output register");

    a_busy_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> o_stall)
        else $error("item accepted during key reduction");

    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value_out < DEC_MOD))
        else $error("result not below 10^8");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall) |=> r_out_v)
        else $error("pending result dropped");

endmodule

// ===== sv/dbc8_key_store.sv =====
// ----------------------------------------------------------------------------
// dbc8_key_store: round key registers
// Takes key writes and reduces each word mod 10^8, a reciprocal quotient
// estimate then one correcting subtract, before storing it.
// ----------------------------------------------------------------------------
module dbc8_key_store import dbc8_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [KEY_W-1:0]               i_cfg_data,
    output logic                           o_busy,
    output logic [NUM_KEYS-1:0][VAL_W-1:0] o_keys
);

    localparam int PROD_W = KEY_W - KEY_PRE_SH + KEY_RECIP_W;

    logic                           r_busy;
    logic                           r_phase;
    logic [KEY_W-1:0]               r_val;
    logic [KIDX_W-1:0]              r_idx;
    logic [KEY_Q_W-1:0]             r_q;
    logic [NUM_KEYS-1:0][VAL_W-1:0] r_keys;

    logic [PROD_W-1:0]  w_prod;
    logic [KEY_W-1:0]   w_rem;
    logic [KEY_Q_W-1:0] n_q;
    logic [VAL_W-1:0]   n_key;

    always_comb begin
        w_prod = PROD_W'(r_val[KEY_W-1:KEY_PRE_SH]) * PROD_W'(KEY_RECIP);
        n_q    = w_prod[KEY_SHIFT +: KEY_Q_W];
        // remainder is below 2*10^8, one subtract finishes it
        w_rem  = r_val - KEY_W'(r_q) * KEY_W'(DEC_MOD);
        n_key  = (w_rem >= KEY_W'(DEC_MOD)) ? VAL_W'(w_rem - KEY_W'(DEC_MOD))
                                            : w_rem[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_keys  <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_q     <= n_q;
                r_phase <= 1'b1;
            end else begin
                r_keys[r_idx] <= n_key;
                r_busy        <= 1'b0;
                r_phase       <= 1'b0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_KEYS))) begin
            // writes beyond the key list are taken and dropped
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_val   <= i_cfg_data;
            r_idx   <= i_cfg_index[KIDX_W-1:0];
        end
    end

    assign o_cfg_ready = !r_busy;
    assign o_busy      = r_busy;
    assign o_keys      = r_keys;

endmodule

// ===== sv/dbc8_round_cell.sv =====
// ----------------------------------------------------------------------------
// dbc8_round_cell: one cipher round, four pipeline stages
// Runs a forward round or an inverse round as the item's kind selects.
// ----------------------------------------------------------------------------
module dbc8_round_cell import dbc8_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_lane            i_lane,
    input  logic [VAL_W-1:0] i_key_enc,
    input  logic [VAL_W-1:0] i_key_dec,
    output t_lane            o_lane
);

    // stage 1: add key (forward) or triple (inverse), reduced mod 10^8
    logic             r1_v, r1_kind;
    logic [VAL_W-1:0] r1_a;
    // stage 2: digit split
    logic             r2_v, r2_kind;
    logic [VAL_W-1:0] r2_a;
    logic [TOP_W-1:0] r2_q;
    logic [3:0]       r2_top;
    logic [1:0]       r2_t;
    // stage 3: rotated value
    logic             r3_v, r3_kind;
    logic [VAL_W+1:0] r3_a;
    // stage 4: result
    logic             r4_v, r4_kind;
    logic [VAL_W-1:0] r4_a;

    logic [VAL_W-1:0] n1_a;
    logic [VAL_W-1:0] n2_a;
    logic [TOP_W-1:0] n2_q;
    logic [3:0]       n2_top;
    logic [1:0]       n2_t;
    logic [VAL_W+1:0] n3_a;
    logic [VAL_W-1:0] n4_a;

    logic [VAL_W:0]          w_sum;
    logic [VAL_W+1:0]        w_trip;
    logic [VAL_W+KEY_W-1:0]  w_prod10;
    logic [1:0]              w_m3;
    logic [VAL_W-1:0]        w_x;
    logic [3:0]              w_low;
    logic [KEY_W-1:0]        w_div3;
    logic [VAL_W-1:0]        w_rr;

    always_comb begin
        w_sum  = {1'b0, i_lane.a} + {1'b0, i_key_enc};
        w_trip = {1'b0, i_lane.a, 1'b0} + {2'b00, i_lane.a};
        if (i_lane.kind == KIND_ENC) begin
            n1_a = (w_sum >= {1'b0, DEC_MOD}) ? VAL_W'(w_sum - {1'b0, DEC_MOD})
                                              : w_sum[VAL_W-1:0];
        end else if (w_trip >= DEC_MOD2) begin
            n1_a = VAL_W'(w_trip - DEC_MOD2);
        end else if (w_trip >= {2'b00, DEC_MOD}) begin
            n1_a = VAL_W'(w_trip - {2'b00, DEC_MOD});
        end else begin
            n1_a = w_trip[VAL_W-1:0];
        end
    end

    always_comb begin
        n2_top = '0;
        for (int k = 1; k < 10; k++) begin
            n2_top = n2_top + 4'(r1_a >= top_scale(4'(k)));
        end
        // rotation keeps the digit sum, so the residue can be taken here
        w_m3     = mod3_val(r1_a);
        n2_t     = (w_m3 == 2'd0) ? 2'd0 : 2'd3 - w_m3;
        w_prod10 = (VAL_W+KEY_W)'(r1_a) * (VAL_W+KEY_W)'(RECIP10);
        n2_q     = w_prod10[VAL_W+KEY_W-1 -: TOP_W];
        if (r1_kind == KIND_ENC) begin
            n2_a = r1_a - top_scale(n2_top);
        end else begin
            n2_a = r1_a;
        end
    end

    always_comb begin
        w_x   = {r2_a[VAL_W-4:0], 3'b000} + {r2_a[VAL_W-2:0], 1'b0} + VAL_W'(r2_top);
        w_low = 4'(r2_a - ({r2_q, 3'b000} + {r2_q, 1'b0}));
        if (r2_kind == KIND_ENC) begin
            n3_a = {2'b00, w_x} + (VAL_W+2)'(r2_t) * (VAL_W+2)'(DEC_MOD);
        end else begin
            n3_a = {2'b00, top_scale(w_low) + VAL_W'(r2_q)};
        end
    end

    always_comb begin
        // exact division by 3 through the inverse of 3 mod 2^32
        w_div3 = KEY_W'(r3_a) * INV3;
        w_rr   = r3_a[VAL_W-1:0];
        if (r3_kind == KIND_ENC) begin
            n4_a = w_div3[VAL_W-1:0];
        end else if (w_rr >= i_key_dec) begin
            n4_a = w_rr - i_key_dec;
        end else begin
            n4_a = w_rr + (DEC_MOD - i_key_dec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_lane.v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_lane.kind;
            r1_a    <= n1_a;
            r2_kind <= r1_kind;
            r2_a    <= n2_a;
            r2_q    <= n2_q;
            r2_top  <= n2_top;
            r2_t    <= n2_t;
            r3_kind <= r2_kind;
            r3_a    <= n3_a;
            r4_kind <= r3_kind;
            r4_a    <= n4_a;
        end
    end

    assign o_lane = {r4_v, r4_kind, r4_a};

endmodule

// ===== tb/dbc8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbc8_checker: result predictor and scoreboard for the decimal cipher unit
// Follows key writes, works out the cipher value for every accepted item and
// compares each accepted result, in order, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module dbc8_checker import dbc8_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_kind,
    input  logic [VAL_W-1:0]     i_value_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [VAL_W-1:0]     i_value_out,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam longint unsigned MOD8     = 64'd100000000;
    localparam longint unsigned TOP7     = 64'd10000000;
    localparam longint unsigned FWD_MULT = 64'd66666667;
    localparam longint unsigned REV_MULT = 64'd3;

    typedef struct {
        logic             kind;
        logic [VAL_W-1:0] src;
        logic [VAL_W-1:0] value;
    } t_cipher_result;

    logic [KEY_W-1:0] key_words [NUM_KEYS];
    t_cipher_result   cipher_q [$];

    function automatic logic [VAL_W-1:0] encipher(input logic [VAL_W-1:0] v);
        longint unsigned a;
        longint unsigned k;
        longint unsigned top;
        a = v;
        for (int r = 0; r < ROUNDS; r++) begin
            k   = key_words[r] % MOD8;
            a   = (a + k) % MOD8;
            top = a / TOP7;
            a   = (a % TOP7) * 10 + top;   // digit rotate left
            a   = (a * FWD_MULT) % MOD8;
        end
        return VAL_W'(a);
    endfunction

    function automatic logic [VAL_W-1:0] decipher(input logic [VAL_W-1:0] v);
        longint unsigned a;
        longint unsigned k;
        a = v;
        for (int r = ROUNDS - 1; r >= 0; r--) begin
            k = key_words[r] % MOD8;
            a = (a * REV_MULT) % MOD8;
            a = (a % 10) * TOP7 + a / 10;  // digit rotate right
            a = (a >= k) ? a - k : a + MOD8 - k;
        end
        return VAL_W'(a);
    endfunction

    always @(posedge i_clk) begin
        t_cipher_result res;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                key_words[i] = '0;
            end
            cipher_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            // out-of-range indexes are dropped by the block
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_KEYS) begin
                key_words[i_cfg_index[KIDX_W-1:0]] = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (cipher_q.size() == 0) begin
                    $display("%0t: value_out unexpected: expected none, got %0d",
                             $time, i_value_out);
                    o_errors <= o_errors + 1;
                end else begin
                    res = cipher_q.pop_front();
                    if (i_value_out !== res.value) begin
                        $display("%0t: value_out (kind %0d, in %0d): expected %0d, got %0d",
                                 $time, res.kind, res.src, res.value, i_value_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                res.kind  = i_kind;
                res.src   = i_value_in;
                res.value = (i_kind == KIND_ENC) ? encipher(i_value_in)
                                                 : decipher(i_value_in);
                cipher_q.push_back(res);
            end
            o_pending <= cipher_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the eight-digit decimal block cipher unit
// Directed extremes of keys and values, then random key settings and items
// under changing idle and stall patterns; the checker does all comparison.
// ----------------------------------------------------------------------------
module tb_top import dbc8_pkg::*; ();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 160;
    localparam int RAND_PHASES  = 8;
    localparam int DRAIN_CYCLES = 4 * ROUNDS + 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 i_kind      = KIND_ENC;
    logic [VAL_W-1:0]     i_value_in  = '0;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [KEY_W-1:0]     i_cfg_data  = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [VAL_W-1:0]     o_value_out;
    logic                 o_cfg_ready;

    int fail_count;
    int pending_count;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    decimal_block_cipher_8digit_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_out (o_value_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    dbc8_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_kind      (i_kind),
        .i_value_in  (i_value_in),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_value_out (o_value_out),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 73;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 73;
            end
            default: begin
                send_idle_pct = 17;
                stall_pct     = 17;
            end
        endcase
    endtask

    task automatic push_item(input logic kind, input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_value_in <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // sender holds off until every outstanding item has come back
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_keys(input logic [KEY_W-1:0] even_key, input logic [KEY_W-1:0] odd_key);
        write_key(CFG_IDX_W'(NUM_KEYS + $urandom_range(NUM_KEYS - 1)), $urandom);
        for (int i = 0; i < NUM_KEYS; i++) begin
            write_key(CFG_IDX_W'(i), (i % 2 == 0) ? even_key : odd_key);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(3))
            0: k = $urandom;
            1: k = $urandom_range(99999999);
            2: k = 32'd100000000 * $urandom_range(42) + $urandom_range(3);
            default: begin
                case ($urandom_range(3))
                    0: k = '0;
                    1: k = '1;
                    2: k = 32'd99999999;
                    default: k = 32'd100000000;
                endcase
            end
        endcase
        return k;
    endfunction

    task automatic load_random_keys();
        write_key(CFG_IDX_W'(NUM_KEYS + $urandom_range(NUM_KEYS - 1)), $urandom);
        for (int i = 0; i < NUM_KEYS; i++) begin
            write_key(CFG_IDX_W'(i), pick_key());
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(9))
            0: v = VAL_W'($urandom);   // whole field, 10^8 and above too
            1: begin
                case ($urandom_range(7))
                    0: v = '0;
                    1: v = 27'd1;
                    2: v = 27'd9999999;
                    3: v = 27'd10000000;
                    4: v = 27'd99999999;
                    5: v = 27'd100000000;
                    6: v = 27'd67108864;
                    default: v = '1;
                endcase
            end
            default: v = VAL_W'($urandom_range(99999999));
        endcase
        return v;
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle(IDLE_NONE);

        // keys still at reset value
        push_item(KIND_ENC, 27'd0);
        push_item(KIND_DEC, 27'd0);
        push_item(KIND_ENC, 27'd99999999);
        push_item(KIND_DEC, 27'd99999999);
        wait_drain();

        load_keys('1, '1);
        push_item(KIND_ENC, 27'd0);
        push_item(KIND_ENC, 27'd99999999);
        push_item(KIND_ENC, 27'd100000000);
        push_item(KIND_ENC, '1);
        push_item(KIND_DEC, 27'd100000000);
        push_item(KIND_DEC, '1);
        push_item(KIND_DEC, 27'd99999999);
        push_item(KIND_ENC, 27'd10000000);
        push_item(KIND_DEC, 27'd9999999);
        wait_drain();

        // keys either side of 10^8
        load_keys(32'd99999999, 32'd100000000);
        push_item(KIND_ENC, 27'd12345678);
        push_item(KIND_DEC, 27'd12345678);
        push_item(KIND_ENC, 27'd1);
        push_item(KIND_DEC, 27'd1);
        push_item(KIND_ENC, 27'd90000000);
        push_item(KIND_DEC, 27'd87654321);
        wait_drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            load_random_keys();
            set_idle(t_idle_mode'(p % 4));
            repeat (PHASE_ITEMS) begin
                push_item(1'($urandom_range(1)), pick_value());
                if ($urandom_range(99) == 0) begin
                    wait_drain();
                end
            end
            wait_drain();
        end

        set_idle(IDLE_NONE);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
